/* sv/jpr_pkg.sv */
// ----------------------------------------------------------------------------
// jpr_pkg
// Shared payload types, register indexes and float constants for the
// plane rotation block.
// ----------------------------------------------------------------------------
package jpr_pkg;

  typedef struct packed {
    logic [31:0] x_in;
    logic [31:0] y_in;
    logic        last_pair;
  } jpr_in_t;

  typedef struct packed {
    logic [31:0] x_out;
    logic [31:0] y_out;
    logic        status;
    logic        last_out;
  } jpr_out_t;

  typedef enum logic [1:0] {
    REG_TANGENT = 2'd0,
    REG_COSINE  = 2'd1,
    REG_PERMUTE = 2'd2
  } jpr_reg_e;

  localparam logic [31:0] OneBits  = 32'h3F80_0000;
  localparam logic [31:0] ZeroBits = 32'h0000_0000;
  localparam logic [31:0] QnanBits = 32'h7FC0_0000;
  localparam logic [31:0] PinfBits = 32'h7F80_0000;

  // item flags that ride with the data through every stage
  typedef struct packed {
    logic        bypass;
    logic        swap;
    logic        scale;
    logic        status;
    logic        last;
    logic [31:0] x;
    logic [31:0] y;
  } jpr_ctl_t;

  // unpacked float: nan/inf/zero flags, sign, unbiased exponent, significand
  typedef struct packed {
    logic        nan;
    logic        inf;
    logic        zero;
    logic        sign;
    logic signed [9:0] exp;
    logic [23:0] man;
  } jpr_fp_t;

  function automatic jpr_fp_t fp_unpack(input logic [31:0] b);
    jpr_fp_t r;
    r.sign = b[31];
    r.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    r.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    r.zero = (b[30:0] == 31'd0);
    if (b[30:23] == 8'd0) begin
      r.exp = -10'sd126;
      r.man = {1'b0, b[22:0]};
    end else begin
      r.exp = $signed({2'b00, b[30:23]}) - 10'sd127;
      r.man = {1'b1, b[22:0]};
    end
    return r;
  endfunction

  // count leading zeros of a 76-bit word
  function automatic logic [6:0] clz76(input logic [75:0] v);
    logic [6:0] n;
    logic       found;
    n = 7'd76;
    found = 1'b0;
    for (int i = 75; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 7'(75 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // round a normalized magnitude (msb at bit 75 represents 2^e) to single
  function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] e,
                                           input logic [75:0] m);
    logic [75:0] sh;
    logic [23:0] keep;
    logic        g, st, up;
    logic [24:0] rk;
    logic signed [11:0] be;
    int          dsh;
    be = e + 12'sd127;
    if (be >= 12'sd255) return {s, PinfBits[30:0]};
    dsh = (be <= 12'sd0) ? (1 - int'(be)) : 0;
    if (dsh > 76) dsh = 76;
    sh = m >> dsh;
    st = 1'b0;
    for (int i = 0; i < 76; i++) if (i < dsh && m[i]) st = 1'b1;
    keep = sh[75:52];
    g = sh[51];
    st = st | (sh[50:0] != 51'd0);
    up = g & (st | keep[0]);
    rk = {1'b0, keep} + {24'd0, up};
    if (be <= 12'sd0) begin
      // subnormal: carry into bit 23 gives smallest normal naturally
      return {s, 8'(rk[23]), rk[22:0]};
    end
    if (rk[24]) begin
      if (be + 12'sd1 >= 12'sd255) return {s, PinfBits[30:0]};
      return {s, 8'(be + 12'sd1), rk[23:1]};
    end
    return {s, be[7:0], rk[22:0]};
  endfunction

endpackage

/* sv/jpr_fma.sv */
// ----------------------------------------------------------------------------
// jpr_fma
// Three-stage fused a*b+c in single precision, one rounding; with
// use_add low it is a plain a*b. Stage 1 multiply, stage 2 align and add,
// stage 3 normalize and round.
// ----------------------------------------------------------------------------
module jpr_fma
  import jpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic        use_add_i,
  output logic [31:0] r_o
);

  jpr_fp_t fa, fb, fc;
  assign fa = fp_unpack(a_i);
  assign fb = fp_unpack(b_i);
  assign fc = fp_unpack(c_i);

  // stage 1
  logic [47:0] prod_d, prod_q;
  logic signed [11:0] pexp_q;
  logic        psign_q, pzero_q, pspec_q;
  logic [31:0] pspec_val_q;
  jpr_fp_t     c1_q;
  logic        add1_q;
  logic        pspec;
  logic [31:0] pspec_val;
  logic        pinf;

  assign prod_d = fa.man * fb.man;

  always_comb begin
    pinf = fa.inf | fb.inf;
    pspec = 1'b0;
    pspec_val = QnanBits;
    if (fa.nan || fb.nan || (use_add_i && fc.nan) ||
        (fa.inf && fb.zero) || (fb.inf && fa.zero)) begin
      pspec = 1'b1;
    end else if (pinf) begin
      pspec = 1'b1;
      if (use_add_i && fc.inf && (fc.sign != (fa.sign ^ fb.sign))) pspec_val = QnanBits;
      else pspec_val = {fa.sign ^ fb.sign, PinfBits[30:0]};
    end else if (use_add_i && fc.inf) begin
      pspec = 1'b1;
      pspec_val = c_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q      <= prod_d;
      pexp_q      <= 12'(fa.exp) + 12'(fb.exp);
      psign_q     <= fa.sign ^ fb.sign;
      pzero_q     <= fa.zero | fb.zero;
      pspec_q     <= pspec;
      pspec_val_q <= pspec_val;
      c1_q        <= fc;
      add1_q      <= use_add_i;
    end
  end

  // stage 2: exact sum on a wide grid, sticky beyond; msb weight 2^(big+2)
  logic [75:0] sum_d, sum_q;
  logic signed [11:0] sexp_d, sexp_q;
  logic        ssign_d, ssign_q, szero_d, szero_q, sspec_q;
  logic [31:0] sspec_val_q, zero_val_d, zero_val_q;

  always_comb begin
    logic [75:0] pm, cm, big, small_v;
    logic signed [11:0] pe, ce, be, de;
    logic        bs, ss_v, pz, cz, stk;
    int          d;
    // product value = prod * 2^(pexp-46), msb at bit 47 -> place at bit 73
    pm = {2'b00, prod_q, 26'd0};
    pe = pexp_q + 12'sd1;        // weight of bit 73
    cm = {2'b00, c1_q.man, 50'd0};
    ce = 12'(c1_q.exp);
    pz = pzero_q;
    cz = c1_q.zero | ~add1_q;
    if (cz) begin
      big = pm; be = pe; bs = psign_q; small_v = 76'd0; ss_v = 1'b0;
    end else if (pz) begin
      big = cm; be = ce; bs = c1_q.sign; small_v = 76'd0; ss_v = 1'b0;
    end else if (pe >= ce) begin
      big = pm; be = pe; bs = psign_q; small_v = cm; ss_v = c1_q.sign;
    end else begin
      big = cm; be = ce; bs = c1_q.sign; small_v = pm; ss_v = psign_q;
    end
    de = be - ((be == pe && !cz && !pz) ? ce : pe);
    if (cz || pz) de = 12'sd0;
    d = int'(de);
    if (d > 75) d = 75;
    stk = 1'b0;
    for (int i = 0; i < 76; i++) if (i < d && small_v[i]) stk = 1'b1;
    small_v = (small_v >> d) | {75'd0, stk};
    if (bs == ss_v) begin
      sum_d = big + small_v;
      ssign_d = bs;
    end else if (big >= small_v) begin
      sum_d = big - small_v;
      ssign_d = bs;
    end else begin
      sum_d = small_v - big;
      ssign_d = ss_v;
    end
    sexp_d = be + 12'sd2;   // bit 75 weight
    szero_d = (sum_d == 76'd0);
    // exact zero: +0 unless both addends negative
    if (cz && pz) zero_val_d = {psign_q & (~add1_q | c1_q.sign), 31'd0};
    else if (pz)  zero_val_d = {c1_q.sign & psign_q, 31'd0};
    else          zero_val_d = ZeroBits;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q       <= sum_d;
      sexp_q      <= sexp_d;
      ssign_q     <= ssign_d;
      szero_q     <= szero_d;
      sspec_q     <= pspec_q;
      sspec_val_q <= pspec_val_q;
      zero_val_q  <= zero_val_d;
    end
  end

  // stage 3: normalize and round
  logic [31:0] res_d;
  always_comb begin
    logic [6:0]  lz;
    logic [75:0] nm;
    lz = clz76(sum_q);
    nm = sum_q << lz;
    if (sspec_q)      res_d = sspec_val_q;
    else if (szero_q) res_d = zero_val_q;
    else              res_d = fp_round(ssign_q, sexp_q - 12'(lz), nm);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r_o <= res_d;
  end

endmodule

/* sv/jacobi_plane_rotation.sv */
// ----------------------------------------------------------------------------
// jacobi_plane_rotation
// Single-precision Jacobi plane rotation in tangent form, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: write tangent (index 0), cosine (1) and permute (2) through the
// cfg port while the block is idle. Each request on the in channel carries
// one x/y element pair; exactly one result leaves on the out channel for
// each request, in order. x'=x+t*y and y'=y-t*x go through a fused
// multiply-add pipe, then, when cosine is not 1.0, a multiply pipe of the
// same unit with one more rounding. A zero tangent passes the pair through
// (swapped with permute) or flags status when cosine is not 1.0.
// Each request passes through two 3-stage float units in series; one
// request per cycle is sustained while results are taken. Every stage advances
// when the output stage is empty or taken, so a receiver stall freezes the
// whole pipe and in_ready_o falls; nothing is lost or repeated.
// Reset clears all valid bits and sets tangent 0, cosine 1.0, permute 0.
// ----------------------------------------------------------------------------
module jacobi_plane_rotation
  import jpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  jpr_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output jpr_out_t    out_data_o
);

  localparam int Depth = 6;

  logic [31:0] tangent_q, cosine_q;
  logic        permute_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tangent_q <= ZeroBits;
      cosine_q  <= OneBits;
      permute_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TANGENT: tangent_q <= cfg_data_i;
        REG_COSINE:  cosine_q  <= cfg_data_i;
        REG_PERMUTE: permute_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv = ~out_valid_o | out_ready_i;
  assign in_ready_o = adv;

  logic [Depth-1:0] vld_q;
  jpr_ctl_t         ctl_q [Depth];
  jpr_ctl_t         ctl_d;

  always_comb begin
    logic unit, tz;
    unit = (cosine_q == OneBits);
    tz   = (tangent_q[30:0] == 31'd0);
    ctl_d.bypass = tz;
    ctl_d.swap   = permute_q & (~tz | unit);
    ctl_d.scale  = ~unit;
    ctl_d.status = tz & ~unit;
    ctl_d.last   = in_data_i.last_pair;
    ctl_d.x      = in_data_i.x_in;
    ctl_d.y      = in_data_i.y_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Depth-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= ctl_d;
      for (int i = 1; i < Depth; i++) ctl_q[i] <= ctl_q[i-1];
    end
  end

  logic [31:0] fa_r, fb_r, ma_r, mb_r;

  jpr_fma u_fma_a (.clk_i, .en_i(adv), .a_i(in_data_i.y_in), .b_i(tangent_q),
                   .c_i(in_data_i.x_in), .use_add_i(1'b1), .r_o(fa_r));
  jpr_fma u_fma_b (.clk_i, .en_i(adv), .a_i({~in_data_i.x_in[31], in_data_i.x_in[30:0]}),
                   .b_i(tangent_q), .c_i(in_data_i.y_in), .use_add_i(1'b1), .r_o(fb_r));
  jpr_fma u_mul_a (.clk_i, .en_i(adv), .a_i(fa_r), .b_i(cosine_q), .c_i(ZeroBits),
                   .use_add_i(1'b0), .r_o(ma_r));
  jpr_fma u_mul_b (.clk_i, .en_i(adv), .a_i(fb_r), .b_i(cosine_q), .c_i(ZeroBits),
                   .use_add_i(1'b0), .r_o(mb_r));

  // fused results wait in three registers beside the multiply pipe
  logic [31:0] fa_dq [3];
  logic [31:0] fb_dq [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      fa_dq[0] <= fa_r;
      fb_dq[0] <= fb_r;
      for (int i = 1; i < 3; i++) begin
        fa_dq[i] <= fa_dq[i-1];
        fb_dq[i] <= fb_dq[i-1];
      end
    end
  end

  always_comb begin
    jpr_ctl_t    c;
    logic [31:0] a, b;
    c = ctl_q[Depth-1];
    a = c.scale ? ma_r : fa_dq[2];
    b = c.scale ? mb_r : fb_dq[2];
    if (c.bypass) begin
      a = c.x;
      b = c.y;
    end
    out_data_o.x_out    = c.swap ? b : a;
    out_data_o.y_out    = c.swap ? a : b;
    out_data_o.status   = c.status;
    out_data_o.last_out = c.last;
  end

  assign out_valid_o = vld_q[Depth-1];

endmodule

/* sv/jpr_checker.sv */
// ----------------------------------------------------------------------------
// jpr_checker
// Port-level checks on the rotation block, bound to the top level.
// ----------------------------------------------------------------------------
module jpr_checker
  import jpr_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input jpr_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken during output stall");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("ready low with empty output");

  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(out_data_o))
    else $error("unknown bits in valid result");

endmodule

bind jacobi_plane_rotation jpr_checker u_jpr_checker (
  .clk_i, .rst_ni, .in_ready_o, .out_valid_o, .out_ready_i, .out_data_o
);
